>>> hdl/bmg_pkg.sv
// Shared constants and types for the Box-Muller Gaussian pair pipeline.
// No dependencies.
package bmg_pkg;

  localparam int unsigned RAD_LAT  = 45;
  localparam int unsigned TRIG_RES = 14;
  localparam int unsigned TRIG_PAD = RAD_LAT - TRIG_RES;
  localparam int unsigned LAT      = RAD_LAT + 2;

  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [15:0] OUT_MAX     = 16'h7FFF;
  localparam logic [15:0] OUT_MIN     = 16'h8000;

  localparam int unsigned COS_STEPS = 5;
  localparam int unsigned SIN_STEPS = 4;

  localparam int unsigned COS_SH [COS_STEPS] = '{37, 36, 35, 34, 31};
  localparam logic [31:0] COS_M [COS_STEPS] = '{
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  localparam int unsigned SIN_SH [SIN_STEPS] = '{37, 36, 35, 33};
  localparam logic [31:0] SIN_M [SIN_STEPS] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };

  typedef struct packed {
    logic [30:0] cm;
    logic        cn;
    logic [30:0] sm;
    logic        sn;
  } trig_t;

  typedef struct packed {
    logic [15:0] cos_v;
    logic [15:0] sin_v;
    logic        sat;
  } res_t;

endpackage

>>> hdl/bmg_radius.sv
// Radius pipeline: log2 by repeated squaring, scale by ln 2, bit-serial sqrt.
// Depends on bmg_pkg.
module bmg_radius (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] u,
  output logic [17:0] r,
  output logic        zero
);
  import bmg_pkg::*;

  logic [4:0]  k;
  logic [31:0] y_r [0:24];
  logic [23:0] f_r [0:24];
  logic [5:0]  e_r [0:24];
  logic [29:0] l_r;
  logic [61:0] lp;
  logic [35:0] rem_r [0:18];
  logic [17:0] q_r [0:18];
  logic        zd_r [0:RAD_LAT-1];

  always_comb begin
    k = '0;
    for (int i = 0; i < 32; i++) begin
      if (u[i]) k = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0]  <= u << (5'd31 - k);
      f_r[0]  <= '0;
      e_r[0]  <= 6'd32 - {1'b0, k};
      zd_r[0] <= (u == 32'd0);
      for (int i = 1; i < RAD_LAT; i++) zd_r[i] <= zd_r[i-1];
    end
  end

  for (genvar i = 0; i < 24; i++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(y_r[i]) * 64'(y_r[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        y_r[i+1] <= sq[63] ? sq[63:32] : sq[62:31];
        f_r[i+1] <= {f_r[i][22:0], sq[63]};
        e_r[i+1] <= e_r[i];
      end
    end
  end

  assign lp = 62'(l_r) * 62'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      l_r      <= {e_r[24], 24'd0} - {6'd0, f_r[24]};
      rem_r[0] <= {1'b0, lp[61:31], 4'd0};
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < 18; i++) begin : g_sqrt
    localparam int unsigned B = 17 - i;
    logic [35:0] trial;
    assign trial = (36'(q_r[i]) << (B + 1)) + (36'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[i] >= trial) begin
          rem_r[i+1] <= rem_r[i] - trial;
          q_r[i+1]   <= q_r[i] | (18'd1 << B);
        end else begin
          rem_r[i+1] <= rem_r[i];
          q_r[i+1]   <= q_r[i];
        end
      end
    end
  end

  assign r    = q_r[18];
  assign zero = zd_r[RAD_LAT-1];

endmodule

>>> hdl/bmg_trig.sv
// Angle pipeline: octant fold, nested Taylor sine and cosine, quadrant map.
// Depends on bmg_pkg.
module bmg_trig (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          u,
  output bmg_pkg::trig_t       trig
);
  import bmg_pkg::*;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        fold;
  } side_t;

  logic        fold;
  logic [29:0] a_r, x_r;
  logic [1:0]  q1_r, q2_r;
  logic        f1_r, f2_r;
  logic [60:0] ax, xx;
  side_t       sb_r [0:10];

  logic [29:0] cp_r [0:COS_STEPS-1];
  logic [30:0] ct_r [1:COS_STEPS];
  logic [30:0] ct_in [0:COS_STEPS-1];
  logic [29:0] sp_r [0:SIN_STEPS-1];
  logic [30:0] st_r [1:SIN_STEPS];
  logic [30:0] st_in [0:SIN_STEPS-1];
  logic [61:0] sx;
  logic [30:0] sv_r, sv2_r;
  logic [30:0] c, s;
  trig_t       res;
  trig_t       dl_r [0:TRIG_PAD];

  assign fold = (u[29:0] > 30'h2000_0000);
  assign ax   = 61'(a_r) * 61'(HALF_PI_Q30);
  assign xx   = 61'(x_r) * 61'(x_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= fold ? 30'(ONE_Q30 - {1'b0, u[29:0]}) : u[29:0];
      q1_r <= u[31:30];
      f1_r <= fold;
      x_r  <= ax[59:30];
      q2_r <= q1_r;
      f2_r <= f1_r;
      sb_r[0] <= '{x: x_r, x2: xx[59:30], quad: q2_r, fold: f2_r};
      for (int i = 1; i <= 10; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  assign ct_in[0] = ONE_Q30;
  assign st_in[0] = ONE_Q30;

  for (genvar j = 0; j < COS_STEPS; j++) begin : g_cos
    logic [60:0] pa;
    logic [61:0] pb, qs;
    if (j > 0) begin : g_in
      assign ct_in[j] = ct_r[j];
    end
    assign pa = 61'(sb_r[2*j].x2) * 61'(ct_in[j]);
    assign pb = 62'(cp_r[j]) * 62'(COS_M[j]);
    assign qs = pb >> COS_SH[j];
    always_ff @(posedge clk) begin
      if (en) begin
        cp_r[j]   <= pa[59:30];
        ct_r[j+1] <= ONE_Q30 - {1'b0, qs[29:0]};
      end
    end
  end

  for (genvar j = 0; j < SIN_STEPS; j++) begin : g_sin
    logic [60:0] pa;
    logic [61:0] pb, qs;
    if (j > 0) begin : g_in
      assign st_in[j] = st_r[j];
    end
    assign pa = 61'(sb_r[2*j].x2) * 61'(st_in[j]);
    assign pb = 62'(sp_r[j]) * 62'(SIN_M[j]);
    assign qs = pb >> SIN_SH[j];
    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[j]   <= pa[59:30];
        st_r[j+1] <= ONE_Q30 - {1'b0, qs[29:0]};
      end
    end
  end

  assign sx = 62'(sb_r[2*SIN_STEPS].x) * 62'(st_r[SIN_STEPS]);

  always_comb begin
    c = sb_r[10].fold ? sv2_r : ct_r[COS_STEPS];
    s = sb_r[10].fold ? ct_r[COS_STEPS] : sv2_r;
    case (sb_r[10].quad)
      QUAD_I:   res = '{cm: c, cn: 1'b0, sm: s, sn: 1'b0};
      QUAD_II:  res = '{cm: s, cn: 1'b1, sm: c, sn: 1'b0};
      QUAD_III: res = '{cm: c, cn: 1'b1, sm: s, sn: 1'b1};
      QUAD_IV:  res = '{cm: s, cn: 1'b0, sm: c, sn: 1'b1};
      default:  res = '{cm: c, cn: 1'b0, sm: s, sn: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r  <= sx[60:30];
      sv2_r <= sv_r;
      dl_r[0] <= res;
      for (int i = 1; i <= TRIG_PAD; i++) dl_r[i] <= dl_r[i-1];
    end
  end

  assign trig = dl_r[TRIG_PAD];

endmodule

>>> hdl/box_muller_gaussian_pair.sv
// Box-Muller Gaussian pair generator, top level: pipeline control, output scaling.
// Depends on bmg_pkg, bmg_radius and bmg_trig.
// Items pass through the radius and angle pipelines, the product and scaling registers and the output register.
// Throughput: one item per cycle while the skid stage is empty, set by the fully pipelined radius and angle paths.
// A two-entry output register and skid stage take one extra item under a stall.
// Reset clears all valid bits; payload registers are not reset.
module box_muller_gaussian_pair (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_uniform_radius,
  input  logic [31:0]        in_uniform_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_normal_cos,
  output logic signed [15:0] out_normal_sin,
  output logic               out_saturated
);
  import bmg_pkg::*;

  logic        en, slot_free;
  logic        vld_r [0:LAT-1];
  logic [17:0] r;
  logic        zero;
  trig_t       trig;
  logic [48:0] pc, ps;
  logic [48:0] pc_r, ps_r;
  logic        cn_r, sn_r, cz_r, sz_r, z_r;
  logic [49:0] rc, rs;
  logic [15:0] mc, ms;
  res_t        lst_nxt, lst_r, out_r, skid_r;
  logic        out_valid_r, skid_v_r;

  assign en        = !skid_v_r;
  assign in_ready  = en;
  assign slot_free = !out_valid_r || out_ready;

  bmg_radius u_radius (
    .clk  (clk),
    .en   (en),
    .u    (in_uniform_radius),
    .r    (r),
    .zero (zero)
  );

  bmg_trig u_trig (
    .clk  (clk),
    .en   (en),
    .u    (in_uniform_angle),
    .trig (trig)
  );

  assign pc = 49'(r) * 49'(trig.cm);
  assign ps = 49'(r) * 49'(trig.sm);

  assign rc = 50'(pc_r) + 50'h0_8000_0000;
  assign rs = 50'(ps_r) + 50'h0_8000_0000;
  assign mc = (rc[49:32] > 18'(OUT_MAX)) ? OUT_MAX : rc[47:32];
  assign ms = (rs[49:32] > 18'(OUT_MAX)) ? OUT_MAX : rs[47:32];

  always_comb begin
    if (z_r) begin
      lst_nxt.cos_v = (cn_r && cz_r) ? OUT_MIN : OUT_MAX;
      lst_nxt.sin_v = (sn_r && sz_r) ? OUT_MIN : OUT_MAX;
    end else begin
      lst_nxt.cos_v = cn_r ? 16'(~mc + 16'd1) : mc;
      lst_nxt.sin_v = sn_r ? 16'(~ms + 16'd1) : ms;
    end
    lst_nxt.sat = z_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r  <= pc;
      ps_r  <= ps;
      cn_r  <= trig.cn;
      sn_r  <= trig.sn;
      cz_r  <= (trig.cm != 31'd0);
      sz_r  <= (trig.sm != 31'd0);
      z_r   <= zero;
      lst_r <= lst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (slot_free) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= vld_r[LAT-1];
      end
    end else if (vld_r[LAT-1] && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_r <= skid_v_r ? skid_r : lst_r;
    end
    if (!slot_free && en) begin
      skid_r <= lst_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_cos = out_r.cos_v;
  assign out_normal_sin = out_r.sin_v;
  assign out_saturated  = out_r.sat;

  assert property (@(posedge clk) disable iff (!rst_n) skid_v_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      ((out_normal_cos == OUT_MAX || out_normal_cos == OUT_MIN) &&
       (out_normal_sin == OUT_MAX || out_normal_sin == OUT_MIN)))
    else $error("saturated item carries an unsaturated value");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_saturated) |->
      (out_normal_cos != OUT_MIN && out_normal_sin != OUT_MIN))
    else $error("rounded magnitude escaped the clamp");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled item dropped");

endmodule
